// File: design/mer_pkg.sv
package mer_pkg;

  localparam int RADIUS_BITS_DEF = 10;
  localparam int COORD_BITS_DEF  = 11;

  localparam logic MODE_START = 1'b0;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_RXSQ_RY,
    MUL_TX_TX,
    MUL_RYSQ_PROD,
    MUL_TY_TY,
    MUL_RXSQ_PROD,
    MUL_RXSQ_RYSQ
  } mul_op_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD4,
    ACC_SUB4
  } acc_op_e;

  typedef struct packed {
    logic    load_start;
    mul_op_e mul_op;
    logic    lat_rxsq;
    logic    lat_rysq;
    logic    init_dec;
    logic    step_r1;
    logic    step_r2;
    acc_op_e acc_op;
    logic    fin_dec;
  } mer_cmd_t;

  typedef struct packed {
    logic r1_fin;
    logic r1_leave;
    logic r2_fin;
  } mer_stat_t;

endpackage

// File: design/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer. A start transfer (mode 0) latches the center and both radii;
// four setup steps follow, in which one shared multiplier forms rx squared, ry squared and
// rx squared times ry and the input is stalled. Each step transfer (mode 1) then delivers
// the four symmetric points of the current offset, updating the decision value from running
// increments. After the step that ends region 1, the region 2 start value is built in seven
// more steps (EN1 to EN7) that use the same multiplier and accumulator, with the input stalled.
// A step while idle is taken and gives nothing. A finished point set waits in the output
// register while the output is stalled, and no transfer is taken then; last marks the final
// point set of the ellipse.
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [COORD_BITS-1:0]        center_x_i,
  input  logic [COORD_BITS-1:0]        center_y_i,
  input  logic [RADIUS_BITS-1:0]       radius_x_i,
  input  logic [RADIUS_BITS-1:0]       radius_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS+1:0] pa_x_o,
  output logic signed [COORD_BITS+1:0] pa_y_o,
  output logic signed [COORD_BITS+1:0] pb_x_o,
  output logic signed [COORD_BITS+1:0] pb_y_o,
  output logic signed [COORD_BITS+1:0] pc_x_o,
  output logic signed [COORD_BITS+1:0] pc_y_o,
  output logic signed [COORD_BITS+1:0] pd_x_o,
  output logic signed [COORD_BITS+1:0] pd_y_o,
  output logic                         last_o
);

  mer_cmd_t  cmd;
  mer_stat_t stat;

  mer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  mer_datapath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_x_i (radius_x_i),
    .radius_y_i (radius_y_i),
    .stat_o     (stat),
    .pa_x_o     (pa_x_o),
    .pa_y_o     (pa_y_o),
    .pb_x_o     (pb_x_o),
    .pb_y_o     (pb_y_o),
    .pc_x_o     (pc_x_o),
    .pc_y_o     (pc_y_o),
    .pd_x_o     (pd_x_o),
    .pd_y_o     (pd_y_o),
    .last_o     (last_o)
  );

endmodule

// File: design/mer_ctrl.sv
module mer_ctrl import mer_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      mode_i,
  input  logic      out_stall_i,
  input  mer_stat_t stat_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output mer_cmd_t  cmd_o
);

  typedef enum logic [13:0] {
    ST_IDLE = 14'h0001,
    ST_R1   = 14'h0002,
    ST_R2   = 14'h0004,
    ST_SU1  = 14'h0008,
    ST_SU2  = 14'h0010,
    ST_SU3  = 14'h0020,
    ST_SU4  = 14'h0040,
    ST_EN1  = 14'h0080,
    ST_EN2  = 14'h0100,
    ST_EN3  = 14'h0200,
    ST_EN4  = 14'h0400,
    ST_EN5  = 14'h0800,
    ST_EN6  = 14'h1000,
    ST_EN7  = 14'h2000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   ready;
  logic   accept;
  logic   emit;

  assign ready      = state_q inside {ST_IDLE, ST_R1, ST_R2};
  assign in_stall_o = !ready || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign emit       = cmd_o.step_r1 || cmd_o.step_r2;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && mode_i == MODE_START) begin
          cmd_o.load_start = 1'b1;
          state_d          = ST_SU1;
        end
      end
      ST_R1: begin
        if (accept) begin
          if (mode_i == MODE_START) begin
            cmd_o.load_start = 1'b1;
            state_d          = ST_SU1;
          end else begin
            cmd_o.step_r1 = 1'b1;
            if (stat_i.r1_fin) begin
              state_d = ST_IDLE;
            end else if (stat_i.r1_leave) begin
              state_d = ST_EN1;
            end
          end
        end
      end
      ST_R2: begin
        if (accept) begin
          if (mode_i == MODE_START) begin
            cmd_o.load_start = 1'b1;
            state_d          = ST_SU1;
          end else begin
            cmd_o.step_r2 = 1'b1;
            if (stat_i.r2_fin) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_SU1: begin
        cmd_o.mul_op = MUL_RX_RX;
        state_d      = ST_SU2;
      end
      ST_SU2: begin
        cmd_o.lat_rxsq = 1'b1;
        cmd_o.mul_op   = MUL_RY_RY;
        state_d        = ST_SU3;
      end
      ST_SU3: begin
        cmd_o.lat_rysq = 1'b1;
        cmd_o.mul_op   = MUL_RXSQ_RY;
        state_d        = ST_SU4;
      end
      ST_SU4: begin
        cmd_o.init_dec = 1'b1;
        state_d        = ST_R1;
      end
      ST_EN1: begin
        cmd_o.mul_op = MUL_TX_TX;
        state_d      = ST_EN2;
      end
      ST_EN2: begin
        cmd_o.mul_op = MUL_RYSQ_PROD;
        state_d      = ST_EN3;
      end
      ST_EN3: begin
        cmd_o.acc_op = ACC_LOAD;
        cmd_o.mul_op = MUL_TY_TY;
        state_d      = ST_EN4;
      end
      ST_EN4: begin
        cmd_o.mul_op = MUL_RXSQ_PROD;
        state_d      = ST_EN5;
      end
      ST_EN5: begin
        cmd_o.acc_op = ACC_ADD4;
        cmd_o.mul_op = MUL_RXSQ_RYSQ;
        state_d      = ST_EN6;
      end
      ST_EN6: begin
        cmd_o.acc_op = ACC_SUB4;
        state_d      = ST_EN7;
      end
      ST_EN7: begin
        cmd_o.fin_dec = 1'b1;
        state_d       = ST_R2;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/mer_datapath.sv
module mer_datapath import mer_pkg::*; #(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  mer_cmd_t                     cmd_i,
  input  logic [COORD_BITS-1:0]        center_x_i,
  input  logic [COORD_BITS-1:0]        center_y_i,
  input  logic [RADIUS_BITS-1:0]       radius_x_i,
  input  logic [RADIUS_BITS-1:0]       radius_y_i,
  output mer_stat_t                    stat_o,
  output logic signed [COORD_BITS+1:0] pa_x_o,
  output logic signed [COORD_BITS+1:0] pa_y_o,
  output logic signed [COORD_BITS+1:0] pb_x_o,
  output logic signed [COORD_BITS+1:0] pb_y_o,
  output logic signed [COORD_BITS+1:0] pc_x_o,
  output logic signed [COORD_BITS+1:0] pc_y_o,
  output logic signed [COORD_BITS+1:0] pd_x_o,
  output logic signed [COORD_BITS+1:0] pd_y_o,
  output logic                         last_o
);

  localparam int SQ_W   = 2 * RADIUS_BITS;
  localparam int X_W    = RADIUS_BITS + 1;
  localparam int Y_W    = RADIUS_BITS + 2;
  localparam int TX_W   = X_W + 1;
  localparam int A_W    = 2 * RADIUS_BITS + 1;
  localparam int B_W    = 2 * RADIUS_BITS + 5;
  localparam int PROD_W = A_W + B_W;
  localparam int DEC_W  = PROD_W + 2;
  localparam int OUT_W  = COORD_BITS + 2;
  localparam int SUM_W  = ((COORD_BITS > X_W) ? COORD_BITS : X_W) + 2;

  logic [COORD_BITS-1:0]    org_x_q, org_y_q;
  logic [RADIUS_BITS-1:0]   rx_q;
  logic [SQ_W-1:0]          rxsq_q, rysq_q;
  logic [X_W-1:0]           off_x_q;
  logic signed [Y_W-1:0]    off_y_q;
  logic signed [DEC_W-1:0]  dx_q, dy_q, dec_q, acc_q, prod_q;

  logic signed [OUT_W-1:0]  pa_x_q, pa_y_q, pb_x_q, pb_y_q;
  logic signed [OUT_W-1:0]  pc_x_q, pc_y_q, pd_x_q, pd_y_q;
  logic                     last_q;

  logic [RADIUS_BITS-1:0]   ry_w;
  logic [TX_W-1:0]          tx;
  logic signed [A_W-1:0]    mul_a;
  logic signed [B_W-1:0]    mul_b;
  logic signed [PROD_W-1:0] mul_full;

  logic signed [DEC_W-1:0]  rxsq_ext, rysq_ext, rx2x2, ry2x2;
  logic signed [DEC_W-1:0]  dx_inc, dy_dec, r1_dy_next;
  logic signed [DEC_W-1:0]  r1_dec_next, r2_dec_next, init_dec_val;
  logic signed [DEC_W-1:0]  acc_adj, fin_dec_val;
  logic signed [Y_W-1:0]    y_dec, r1_y_next;
  logic [X_W-1:0]           x_inc;
  logic                     dec_neg, dec_pos;

  logic signed [SUM_W-1:0]  org_x_s, org_y_s, off_x_s, off_y_s;
  logic signed [SUM_W-1:0]  xp, xm, yp, ym;

  assign ry_w = off_y_q[RADIUS_BITS-1:0];
  assign tx   = {off_x_q, 1'b1};

  assign rxsq_ext = {{(DEC_W-SQ_W){1'b0}}, rxsq_q};
  assign rysq_ext = {{(DEC_W-SQ_W){1'b0}}, rysq_q};
  assign rx2x2    = {rxsq_ext[DEC_W-2:0], 1'b0};
  assign ry2x2    = {rysq_ext[DEC_W-2:0], 1'b0};

  assign dx_inc  = dx_q + ry2x2;
  assign dy_dec  = dy_q - rx2x2;
  assign dec_neg = dec_q[DEC_W-1];
  assign dec_pos = !dec_neg && (dec_q != '0);
  assign y_dec   = off_y_q - {{(Y_W-1){1'b0}}, 1'b1};
  assign x_inc   = off_x_q + {{(X_W-1){1'b0}}, 1'b1};

  assign r1_y_next  = dec_neg ? off_y_q : y_dec;
  assign r1_dy_next = dec_neg ? dy_q : dy_dec;

  assign stat_o.r1_fin   = r1_y_next[Y_W-1];
  assign stat_o.r1_leave = dx_inc > r1_dy_next;
  assign stat_o.r2_fin   = y_dec[Y_W-1];

  assign r1_dec_next = dec_neg ? (dec_q + dx_inc + rysq_ext)
                               : (dec_q + dx_inc - dy_dec + rysq_ext);
  assign r2_dec_next = dec_pos ? (dec_q + rxsq_ext - dy_dec)
                               : (dec_q + dx_inc - dy_dec + rxsq_ext);
  assign init_dec_val = rysq_ext - prod_q
                      + {{(DEC_W-SQ_W+2){1'b0}}, rxsq_q[SQ_W-1:2]};

  // Division by four that rounds toward zero.
  assign acc_adj     = acc_q + {{(DEC_W-2){1'b0}}, {2{acc_q[DEC_W-1]}}};
  assign fin_dec_val = {{2{acc_adj[DEC_W-1]}}, acc_adj[DEC_W-1:2]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      MUL_RX_RX: begin
        mul_a = {{(A_W-RADIUS_BITS){1'b0}}, rx_q};
        mul_b = {{(B_W-RADIUS_BITS){1'b0}}, rx_q};
      end
      MUL_RY_RY: begin
        mul_a = {{(A_W-RADIUS_BITS){1'b0}}, ry_w};
        mul_b = {{(B_W-RADIUS_BITS){1'b0}}, ry_w};
      end
      MUL_RXSQ_RY: begin
        mul_a = {{(A_W-SQ_W){1'b0}}, rxsq_q};
        mul_b = {{(B_W-RADIUS_BITS){1'b0}}, ry_w};
      end
      MUL_TX_TX: begin
        mul_a = {{(A_W-TX_W){1'b0}}, tx};
        mul_b = {{(B_W-TX_W){1'b0}}, tx};
      end
      MUL_RYSQ_PROD: begin
        mul_a = {{(A_W-SQ_W){1'b0}}, rysq_q};
        mul_b = prod_q[B_W-1:0];
      end
      MUL_TY_TY: begin
        mul_a = {{(A_W-Y_W){y_dec[Y_W-1]}}, y_dec};
        mul_b = {{(B_W-Y_W){y_dec[Y_W-1]}}, y_dec};
      end
      MUL_RXSQ_PROD: begin
        mul_a = {{(A_W-SQ_W){1'b0}}, rxsq_q};
        mul_b = prod_q[B_W-1:0];
      end
      MUL_RXSQ_RYSQ: begin
        mul_a = {{(A_W-SQ_W){1'b0}}, rxsq_q};
        mul_b = {{(B_W-SQ_W){1'b0}}, rysq_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  assign org_x_s = {{(SUM_W-COORD_BITS){1'b0}}, org_x_q};
  assign org_y_s = {{(SUM_W-COORD_BITS){1'b0}}, org_y_q};
  assign off_x_s = {{(SUM_W-X_W){1'b0}}, off_x_q};
  assign off_y_s = {{(SUM_W-Y_W){off_y_q[Y_W-1]}}, off_y_q};
  assign xp      = org_x_s + off_x_s;
  assign xm      = org_x_s - off_x_s;
  assign yp      = org_y_s + off_y_s;
  assign ym      = org_y_s - off_y_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      org_x_q <= center_x_i;
      org_y_q <= center_y_i;
      rx_q    <= radius_x_i;
      off_x_q <= '0;
      off_y_q <= {2'b00, radius_y_i};
      dx_q    <= '0;
    end
    if (cmd_i.mul_op != MUL_NONE) begin
      prod_q <= {{2{mul_full[PROD_W-1]}}, mul_full};
    end
    if (cmd_i.lat_rxsq) begin
      rxsq_q <= prod_q[SQ_W-1:0];
    end
    if (cmd_i.lat_rysq) begin
      rysq_q <= prod_q[SQ_W-1:0];
    end
    if (cmd_i.init_dec) begin
      dy_q  <= {prod_q[DEC_W-2:0], 1'b0};
      dec_q <= init_dec_val;
    end
    if (cmd_i.step_r1) begin
      off_x_q <= x_inc;
      dx_q    <= dx_inc;
      dec_q   <= r1_dec_next;
      if (!dec_neg) begin
        off_y_q <= y_dec;
        dy_q    <= dy_dec;
      end
    end
    if (cmd_i.step_r2) begin
      off_y_q <= y_dec;
      dy_q    <= dy_dec;
      dec_q   <= r2_dec_next;
      if (!dec_pos) begin
        off_x_q <= x_inc;
        dx_q    <= dx_inc;
      end
    end
    case (cmd_i.acc_op)
      ACC_HOLD: begin
        acc_q <= acc_q;
      end
      ACC_LOAD: begin
        acc_q <= prod_q;
      end
      ACC_ADD4: begin
        acc_q <= acc_q + {prod_q[DEC_W-3:0], 2'b00};
      end
      ACC_SUB4: begin
        acc_q <= acc_q - {prod_q[DEC_W-3:0], 2'b00};
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
    if (cmd_i.fin_dec) begin
      dec_q <= fin_dec_val;
    end
    if (cmd_i.step_r1 || cmd_i.step_r2) begin
      pa_x_q <= xp[OUT_W-1:0];
      pa_y_q <= yp[OUT_W-1:0];
      pb_x_q <= xm[OUT_W-1:0];
      pb_y_q <= ym[OUT_W-1:0];
      pc_x_q <= xp[OUT_W-1:0];
      pc_y_q <= ym[OUT_W-1:0];
      pd_x_q <= xm[OUT_W-1:0];
      pd_y_q <= yp[OUT_W-1:0];
      last_q <= cmd_i.step_r1 ? stat_o.r1_fin : stat_o.r2_fin;
    end
  end

  assign pa_x_o = pa_x_q;
  assign pa_y_o = pa_y_q;
  assign pb_x_o = pb_x_q;
  assign pb_y_o = pb_y_q;
  assign pc_x_o = pc_x_q;
  assign pc_y_o = pc_y_q;
  assign pd_x_o = pd_x_q;
  assign pd_y_o = pd_y_q;
  assign last_o = last_q;

endmodule

// File: design/mer_checker.sv
module mer_checker import mer_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         mode_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [COORD_BITS+1:0] pa_x_o,
  input logic signed [COORD_BITS+1:0] pa_y_o,
  input logic signed [COORD_BITS+1:0] pb_x_o,
  input logic signed [COORD_BITS+1:0] pb_y_o,
  input logic signed [COORD_BITS+1:0] pc_x_o,
  input logic signed [COORD_BITS+1:0] pc_y_o,
  input logic signed [COORD_BITS+1:0] pd_x_o,
  input logic signed [COORD_BITS+1:0] pd_y_o
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_sym_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pa_x_o == pc_x_o) && (pb_x_o == pd_x_o))
    else $error("x coordinates of the point set are not symmetric");

  a_sym_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pa_y_o == pd_y_o) && (pb_y_o == pc_y_o))
    else $error("y coordinates of the point set are not symmetric");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == MODE_START) |=> in_stall_o)
    else $error("input taken during setup after a start transfer");

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(.COORD_BITS(COORD_BITS)) u_mer_checker (.*);
